[hdl/rrss_pkg.sv]
// Package with types, codes and constants of the round-robin slice scheduler.
`timescale 1ns / 1ps

package rrss_pkg;

  localparam int unsigned MAX_JOBS_DEF   = 32;
  localparam int unsigned BURST_BITS_DEF = 10;

  localparam int unsigned TQ_W      = 10;
  localparam int unsigned BURST_IN_W = 10;
  localparam int unsigned TIME_W    = 15;
  localparam int unsigned JIDX_W    = 5;
  localparam int unsigned WLEFT_W   = 10;
  localparam int unsigned S_DATA_W  = 16;
  localparam int unsigned S_USER_W  = 2;
  localparam int unsigned M_DATA_W  = 80;
  localparam int unsigned M_USER_W  = 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [TQ_W-1:0] TQ_RESET = 10'd4;
  localparam logic REG_TIME_QUANTUM = 1'b0;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SLICE    = 2'd1,
    ST_ALL_DONE = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CALC,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic in_load;
    logic do_clear;
    logic do_add;
    logic do_full;
    logic do_none;
    logic scan_init;
    logic scan_step;
    logic scan_miss;
    logic calc;
    logic push;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic full;
    logic scan_done;
    logic pend_hit;
    logic out_free;
  } sts_t;

endpackage

[hdl/round_robin_slice_scheduler_top.sv]
// Top level of the round-robin slice scheduler with request stream, result stream and APB port.
//
//   channel   direction  payload
//   s_axis    in         tuser: req_type; tdata: burst_length
//   m_axis    out        tuser: status; tdata: job_index .. turnaround_time
//   apb       in/out     register 0 at byte address 0: time_quantum
//
// A request is accepted in the idle state and then decoded; every request but advance then goes
// straight to the result push. An advance request checks one table entry per cycle in the
// pending-bit scan over the job table, then computes a slice or reports all done, and pushes it.
// Reset empties the table, zeroes time and sets the quantum to 4.
// A new request is accepted while the previous result waits at the output.
`timescale 1ns / 1ps

module round_robin_slice_scheduler_top
  import rrss_pkg::*;
#(
  parameter int unsigned MAX_JOBS   = MAX_JOBS_DEF,
  parameter int unsigned BURST_BITS = BURST_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,  // burst_length[9:0], zero pad
  input  logic [S_USER_W-1:0] s_axis_tuser_i,  // req_type[1:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // job_index[4:0], slice_start[19:5], slice_end[34:20], work_left[44:35],
  // job_finished[45], waiting_time[60:46], turnaround_time[75:61], zero pad
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  output logic [M_USER_W-1:0] m_axis_tuser_o,  // status[1:0]
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic [TQ_W-1:0] time_quantum_q;
  logic            reg_sel;
  logic            in_ready;
  cmd_t            cmd;
  sts_t            sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TIME_QUANTUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_quantum_q <= TQ_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      time_quantum_q <= pwdata[TQ_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(time_quantum_q) : '0;

  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  assign s_axis_tready_o = in_ready;

  rrss_dp #(
    .MAX_JOBS   (MAX_JOBS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .time_quantum_i (time_quantum_q),
    .in_user_i      (s_axis_tuser_i),
    .in_data_i      (s_axis_tdata_i),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_user_o     (m_axis_tuser_o),
    .out_data_o     (m_axis_tdata_o)
  );

endmodule

[hdl/rrss_ctrl.sv]
// Controller state machine of the round-robin slice scheduler.
`timescale 1ns / 1ps

module rrss_ctrl
  import rrss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.req == REQ_ADVANCE) state_d = S_SCAN;
        else state_d = S_PUSH;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_PUSH;
        else if (sts_i.pend_hit) state_d = S_CALC;
      end
      S_CALC: state_d = S_PUSH;
      S_PUSH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.in_load = in_valid_i;
      end
      S_DECODE: begin
        case (sts_i.req)
          REQ_CLEAR:   cmd_o.do_clear = 1'b1;
          REQ_ADD: begin
            if (sts_i.full) cmd_o.do_full = 1'b1;
            else cmd_o.do_add = 1'b1;
          end
          REQ_ADVANCE: cmd_o.scan_init = 1'b1;
          default:     cmd_o.do_none = 1'b1;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_done) cmd_o.scan_miss = 1'b1;
        else if (!sts_i.pend_hit) cmd_o.scan_step = 1'b1;
      end
      S_CALC: cmd_o.calc = 1'b1;
      S_PUSH: cmd_o.push = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[hdl/rrss_dp.sv]
// Datapath of the round-robin slice scheduler: job table, scan, slice arithmetic, result stage.
`timescale 1ns / 1ps

module rrss_dp
  import rrss_pkg::*;
#(
  parameter int unsigned MAX_JOBS   = MAX_JOBS_DEF,
  parameter int unsigned BURST_BITS = BURST_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [TQ_W-1:0]        time_quantum_i,
  input  logic [S_USER_W-1:0]    in_user_i,
  input  logic [S_DATA_W-1:0]    in_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [M_USER_W-1:0]    out_user_o,
  output logic [M_DATA_W-1:0]    out_data_o
);

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned W     = (BURST_BITS > TQ_W) ? BURST_BITS : TQ_W;
  localparam int unsigned EW    = (BURST_BITS > TIME_W) ? BURST_BITS : TIME_W;
  localparam int unsigned TW    = (W > TIME_W) ? W : TIME_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

  // Job table.
  logic [BURST_BITS-1:0] burst_mem [MAX_JOBS];
  logic [BURST_BITS-1:0] done_mem  [MAX_JOBS];
  logic [BURST_BITS-1:0] rd_burst_q, rd_done_q;
  logic [MAX_JOBS-1:0]   pend_q;

  req_e                  req_q;
  logic [BURST_BITS-1:0] burst_in_q;
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      ptr_q;
  logic [TIME_W-1:0]     time_q;
  logic [IDX_W-1:0]      pos_q;
  logic [CNT_W-1:0]      step_q;

  // Result held for the output stage.
  status_e               res_status_q;
  logic [JIDX_W-1:0]     res_idx_q;
  logic [TIME_W-1:0]     res_start_q, res_end_q, res_wait_q, res_turn_q;
  logic [WLEFT_W-1:0]    res_left_q;
  logic                  res_fin_q;

  logic                  out_valid_q;
  logic [M_USER_W-1:0]   out_user_q;
  logic [M_DATA_W-1:0]   out_data_q;

  logic [BURST_BITS+BURST_IN_W-1:0] burst_ext;
  logic [IDX_W-1:0]      cnt_idx;
  logic [CNT_W-1:0]      pos_inc, ptr_ext;
  logic [IDX_W-1:0]      pos_next;
  logic [JIDX_W+IDX_W-1:0] pos_ext, cnt_ext;

  assign burst_ext = {{BURST_BITS{1'b0}}, in_data_i[BURST_IN_W-1:0]};
  assign cnt_idx   = count_q[IDX_W-1:0];
  assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
  assign pos_next  = (pos_inc < count_q) ? pos_inc[IDX_W-1:0] : '0;
  assign ptr_ext   = CNT_W'(ptr_q);
  assign pos_ext   = {{JIDX_W{1'b0}}, pos_q};
  assign cnt_ext   = {{JIDX_W{1'b0}}, cnt_idx};

  // Slice arithmetic.
  logic [W-1:0]          q_w, remain_w, grant_w;
  logic [BURST_BITS-1:0] remain;
  logic                  fin;
  logic [BURST_BITS-1:0] done_new;
  logic [TW-1:0]         time_sum;
  logic [TIME_W-1:0]     time_new;
  logic [EW-1:0]         wait_w, turn_w;
  logic [W-1:0]          left_w;

  always_comb begin
    q_w      = (time_quantum_i == '0) ? W'(1) : W'(time_quantum_i);
    remain   = (rd_burst_q > rd_done_q) ? (rd_burst_q - rd_done_q) : '0;
    remain_w = W'(remain);
    fin      = !(remain_w > q_w);
    grant_w  = fin ? remain_w : q_w;
    done_new = rd_done_q + grant_w[BURST_BITS-1:0];
    time_sum = TW'(time_q) + TW'(grant_w);
    time_new = time_sum[TIME_W-1:0];
    left_w   = remain_w - grant_w;
    wait_w   = EW'(time_q) - EW'(rd_done_q);
    turn_w   = EW'(wait_w[TIME_W-1:0]) + EW'(rd_burst_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      burst_mem[cnt_idx] <= burst_in_q;
    end
    rd_burst_q <= burst_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      done_mem[cnt_idx] <= '0;
    end else if (cmd_i.calc) begin
      done_mem[pos_q] <= done_new;
    end
    rd_done_q <= done_mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      time_q  <= '0;
    end else begin
      if (cmd_i.do_clear) begin
        pend_q  <= '0;
        count_q <= '0;
        ptr_q   <= '0;
        time_q  <= '0;
      end else if (cmd_i.do_add) begin
        pend_q[cnt_idx] <= 1'b1;
        count_q         <= count_q + CNT_W'(1);
      end else if (cmd_i.calc) begin
        if (fin) pend_q[pos_q] <= 1'b0;
        time_q <= time_new;
        ptr_q  <= pos_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      req_q      <= req_e'(in_user_i);
      burst_in_q <= burst_ext[BURST_BITS-1:0];
    end
    if (cmd_i.scan_init) begin
      pos_q  <= (ptr_ext < count_q) ? ptr_q : '0;
      step_q <= '0;
    end else if (cmd_i.scan_step) begin
      pos_q  <= pos_next;
      step_q <= step_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_clear || cmd_i.do_full || cmd_i.do_none || cmd_i.scan_miss
        || cmd_i.do_add) begin
      res_status_q <= cmd_i.do_full ? ST_FULL :
                      (cmd_i.scan_miss ? ST_ALL_DONE : ST_ACCEPTED);
      res_idx_q    <= cmd_i.do_add ? cnt_ext[JIDX_W-1:0] : '0;
      res_start_q  <= '0;
      res_end_q    <= '0;
      res_left_q   <= '0;
      res_fin_q    <= 1'b0;
      res_wait_q   <= '0;
      res_turn_q   <= '0;
    end else if (cmd_i.calc) begin
      res_status_q <= ST_SLICE;
      res_idx_q    <= pos_ext[JIDX_W-1:0];
      res_start_q  <= time_q;
      res_end_q    <= time_new;
      res_left_q   <= left_w[WLEFT_W-1:0];
      res_fin_q    <= fin;
      res_wait_q   <= fin ? wait_w[TIME_W-1:0] : '0;
      res_turn_q   <= fin ? turn_w[TIME_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_user_q <= res_status_q;
      out_data_q <= {4'b0, res_turn_q, res_wait_q, res_fin_q, res_left_q,
                     res_end_q, res_start_q, res_idx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

  assign sts_o.req       = req_q;
  assign sts_o.full      = (count_q >= MAX_CNT);
  assign sts_o.scan_done = (step_q == count_q);
  assign sts_o.pend_hit  = pend_q[pos_q];
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT) else $error("job count beyond table size");

  a_grant_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.calc |-> (CNT_W'(pos_q) < count_q && pend_q[pos_q]))
    else $error("slice granted outside the table or to a finished job");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_clear |=> (count_q == '0 && pend_q == '0 && time_q == '0))
    else $error("clear did not empty the table");

  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || out_ready_i))
    else $error("result stage overwritten before it was taken");
`endif

endmodule
